FILE: rtl/core/cmpl_pkg.sv
// ---------------------------------------------------------------------------
// cmpl_pkg: shared types for the compacting list with min/max
// Command and status codes, controller states and the links that pass
// between neighboring cells of the list.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmpl_pkg;

  localparam int ValueW = 32;
  localparam int PosW   = 7;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  // Command broadcast to every cell. The go bit is set only for an accepted
  // item that changes the list.
  typedef struct packed {
    logic              go;
    cmd_t              op;
    logic [PosW-1:0]   pos;
    logic [ValueW-1:0] value;
  } cell_cmd_t;

  // Passed from a cell to the cell above it: occupancy and the running
  // minimum and maximum over all occupied cells below.
  typedef struct packed {
    logic                     occ;
    logic                     ok;
    logic signed [ValueW-1:0] mn;
    logic signed [ValueW-1:0] mx;
  } up_link_t;

  // Passed from a cell to the cell below it, used when entries move down.
  typedef struct packed {
    logic              occ;
    logic [ValueW-1:0] val;
  } down_link_t;

endpackage

FILE: rtl/core/compacting_list_with_min_max.sv
// ---------------------------------------------------------------------------
// compacting_list_with_min_max: ordered list with append/overwrite/delete
// A row of DEPTH cells holds the list; every command returns a status, the
// new count and the minimum and maximum over the valid entries.
// ---------------------------------------------------------------------------
// Usage:
// Commands enter on the s_ group; one result item leaves on the m_ group for
// every command item. Append puts the value after the last entry, overwrite
// replaces the entry at a position, delete removes it and moves all later
// entries down by one, query changes nothing.
// The list is updated in every cell at the edge that accepts the command.
// Minimum and maximum then ripple up the row of cells, one cell per cycle,
// before the result is loaded. The block takes one command at a time:
// s_tready is high only while no command is in progress, so a new command
// can follow only once the previous result has been loaded.
// The result sits in an output register. If the receiver stalls, a new
// command may still be accepted and scanned; it waits for that register to
// drain before its own result is loaded.
// Reset empties the list and drops any pending result; the stored values
// themselves are not cleared, since entries above the count are never read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module compacting_list_with_min_max
  import cmpl_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata fields, lowest bit first: command[1:0], position[8:2],
  // value[40:9], zero pad[47:41].
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata fields, lowest bit first: status[1:0], entry_count[9:2],
  // is_empty[10], smallest[42:11], largest[74:43], zero pad[79:75].
  output logic [79:0] m_tdata
);

  // Widths that follow from the depth: the count runs from 0 to DEPTH.
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int XW    = (CW > PosW) ? CW : PosW;

  // Fields of the incoming item.
  cmd_t              cmd_in;
  logic [PosW-1:0]   pos_in;
  logic [ValueW-1:0] val_in;

  assign cmd_in = cmd_t'(s_tdata[1:0]);
  assign pos_in = s_tdata[8:2];
  assign val_in = s_tdata[40:9];

  // Controller state and registers.
  state_t         state;
  state_t         state_next;
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  logic [CW-1:0]  wait_cnt;
  logic [CW-1:0]  wait_cnt_next;
  status_t        status_q;
  status_t        status_calc;
  logic           accept;
  logic           load_out;
  logic           full;
  logic           bad_pos;

  // Output register.
  status_t                  out_status;
  logic [7:0]               out_count;
  logic                     out_empty;
  logic signed [ValueW-1:0] out_min;
  logic signed [ValueW-1:0] out_max;

  // Row of cells.
  cell_cmd_t  cell_cmd;
  up_link_t   up   [DEPTH+1];
  down_link_t down [DEPTH+1];

  assign accept  = s_tvalid && s_tready;
  assign full    = (count == CW'(DEPTH));
  // A position must lie below the count; positions past the depth always do
  // not, because the count never exceeds the depth.
  assign bad_pos = (XW'(pos_in) >= XW'(count));

  // Status and new count for the incoming command.
  always_comb begin
    status_calc = ST_DONE;
    count_next  = count;
    unique case (cmd_in)
      CMD_APPEND: begin
        if (full) begin
          status_calc = ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      CMD_WRITE: begin
        if (bad_pos) begin
          status_calc = ST_BADPOS;
        end
      end
      CMD_DELETE: begin
        if (bad_pos) begin
          status_calc = ST_BADPOS;
        end else begin
          count_next = count - CW'(1);
        end
      end
      CMD_QUERY: begin
      end
      default: begin
      end
    endcase
  end

  // Every cell sees the command at the accepting edge; a rejected command
  // or a query leaves the row untouched.
  assign cell_cmd.go    = accept && (status_calc == ST_DONE) && (cmd_in != CMD_QUERY);
  assign cell_cmd.op    = cmd_in;
  assign cell_cmd.pos   = pos_in;
  assign cell_cmd.value = val_in;

  // The bottom cell behaves as if an occupied neighbor lay below it, with no
  // running extremes yet. The top cell pulls in an empty slot on delete.
  assign up[0].occ          = 1'b1;
  assign up[0].ok           = 1'b0;
  assign up[0].mn           = '0;
  assign up[0].mx           = '0;
  assign down[DEPTH].occ    = 1'b0;
  assign down[DEPTH].val    = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cmpl_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cell_cmd),
      .from_below (up[i]),
      .from_above (down[i+1]),
      .to_above   (up[i+1]),
      .to_below   (down[i])
    );
  end

  // Controller: after a command the extremes ripple to the top of the row
  // while wait_cnt counts down to zero; then the result is loaded.
  always_comb begin
    state_next    = state;
    wait_cnt_next = wait_cnt;
    s_tready      = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next    = S_SCAN;
          wait_cnt_next = CW'(DEPTH);
        end
      end
      S_SCAN: begin
        if (wait_cnt != '0) begin
          wait_cnt_next = wait_cnt - CW'(1);
        end else if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      wait_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      wait_cnt <= wait_cnt_next;
      if (accept) begin
        count <= count_next;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= status_calc;
    end
    if (load_out) begin
      out_status <= status_q;
      out_count  <= 8'(count);
      out_empty  <= (count == '0);
      out_min    <= up[DEPTH].ok ? up[DEPTH].mn : '0;
      out_max    <= up[DEPTH].ok ? up[DEPTH].mx : '0;
    end
  end

  assign m_tdata = {5'd0, out_max, out_min, out_empty, out_count, out_status};

endmodule

FILE: rtl/core/cmpl_cell.sv
// ---------------------------------------------------------------------------
// cmpl_cell: one entry of the compacting list
// Holds one value and its occupied flag, applies the broadcast command, and
// folds its value into the running minimum and maximum that ripple upward.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmpl_cell
  import cmpl_pkg::*;
#(
  parameter int IDX_W = 7,
  parameter int INDEX = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  cell_cmd_t  cmd,
  input  up_link_t   from_below,
  input  down_link_t from_above,
  output up_link_t   to_above,
  output down_link_t to_below
);

  localparam int PW = (IDX_W > PosW) ? IDX_W : PosW;

  logic                     occ;
  logic signed [ValueW-1:0] val;
  logic                     occ_next;
  logic signed [ValueW-1:0] val_next;
  logic                     ok;
  logic signed [ValueW-1:0] mn;
  logic signed [ValueW-1:0] mx;
  logic [PW-1:0]            pos_x;
  logic [PW-1:0]            idx;
  logic                     at_pos;
  logic                     from_pos;

  assign pos_x    = PW'(cmd.pos);
  assign idx      = PW'(INDEX);
  assign at_pos   = (idx == pos_x);
  assign from_pos = (idx >= pos_x);

  always_comb begin
    occ_next = occ;
    val_next = val;
    if (cmd.go) begin
      case (cmd.op)
        CMD_APPEND: begin
          // The first free cell above an occupied one takes the value.
          if (!occ && from_below.occ) begin
            occ_next = 1'b1;
            val_next = cmd.value;
          end
        end
        CMD_WRITE: begin
          if (at_pos) begin
            val_next = cmd.value;
          end
        end
        CMD_DELETE: begin
          if (from_pos) begin
            occ_next = from_above.occ;
            val_next = from_above.val;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
      ok  <= 1'b0;
    end else begin
      occ <= occ_next;
      if (occ) begin
        ok <= 1'b1;
      end else begin
        ok <= from_below.ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
    if (occ && from_below.ok) begin
      mn <= (val < from_below.mn) ? val : from_below.mn;
      mx <= (val > from_below.mx) ? val : from_below.mx;
    end else if (occ) begin
      mn <= val;
      mx <= val;
    end else begin
      mn <= from_below.mn;
      mx <= from_below.mx;
    end
  end

  assign to_above.occ = occ;
  assign to_above.ok  = ok;
  assign to_above.mn  = mn;
  assign to_above.mx  = mx;
  assign to_below.occ = occ;
  assign to_below.val = val;

endmodule
